// ===== rtl/eul_pkg.sv =====
package eul_pkg;

    localparam int VTX_W       = 3;
    localparam int VTX_SPAN    = 8;
    localparam int STORE_DEPTH = 29;
    localparam int ADDR_W      = 5;
    localparam int EDGE_W      = 5;

    typedef logic [VTX_W-1:0]  t_vtx;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [EDGE_W-1:0] t_edges;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WALK,
        S_POP,
        S_DONE,
        S_FAIL,
        S_RD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic add;
        logic remove;
        logic clear;
        t_vtx rd_vtx;
        t_vtx va;
        t_vtx vb;
    } t_adj_cmd;

    typedef struct packed {
        logic row_nz;
        t_vtx low_nbr;
        logic odd;
        logic edges_left;
    } t_adj_stat;

    function automatic int eff_vertices(input int n);
        int r;
        r = (n < VTX_SPAN) ? n : VTX_SPAN;
        return r;
    endfunction

endpackage

// ===== rtl/eul_ram.sv =====
module eul_ram (
    input  logic          i_clk,
    input  logic          i_we,
    input  eul_pkg::t_addr i_waddr,
    input  eul_pkg::t_vtx  i_wdata,
    input  logic          i_re,
    input  eul_pkg::t_addr i_raddr,
    output eul_pkg::t_vtx  o_rdata
);
    import eul_pkg::*;

    t_vtx r_mem [STORE_DEPTH];
    t_vtx r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/eul_adj.sv =====
module eul_adj #(
    parameter int NUM_VERTICES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  eul_pkg::t_adj_cmd  i_cmd,
    output eul_pkg::t_adj_stat o_stat
);
    import eul_pkg::*;

    localparam int NV = eff_vertices(NUM_VERTICES);

    logic [VTX_SPAN-1:0] r_adj [VTX_SPAN];
    t_edges              r_edges;
    logic [VTX_SPAN-1:0] s_row;
    t_vtx                s_low;
    logic                s_add_ok;

    assign s_row = r_adj[i_cmd.rd_vtx];

    always_comb begin
        s_low = '0;
        for (int i = VTX_SPAN - 1; i >= 0; i--) begin
            if (s_row[i]) begin
                s_low = VTX_W'(i);
            end
        end
    end

    // duplicate check uses the read row, which is addressed by va during an add
    assign s_add_ok = i_cmd.add && (i_cmd.va != i_cmd.vb)
                    && ({1'b0, i_cmd.va} < (VTX_W+1)'(NV))
                    && ({1'b0, i_cmd.vb} < (VTX_W+1)'(NV))
                    && !s_row[i_cmd.vb];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < VTX_SPAN; i++) begin
                r_adj[i] <= '0;
            end
            r_edges <= '0;
        end else if (s_add_ok) begin
            r_adj[i_cmd.va][i_cmd.vb] <= 1'b1;
            r_adj[i_cmd.vb][i_cmd.va] <= 1'b1;
            r_edges <= EDGE_W'(r_edges + 1'b1);
        end else if (i_cmd.remove) begin
            r_adj[i_cmd.va][i_cmd.vb] <= 1'b0;
            r_adj[i_cmd.vb][i_cmd.va] <= 1'b0;
            r_edges <= EDGE_W'(r_edges - 1'b1);
        end
    end

    assign o_stat.row_nz     = |s_row;
    assign o_stat.low_nbr    = s_low;
    assign o_stat.odd        = ^s_row;
    assign o_stat.edges_left = (r_edges != '0);

endmodule

// ===== rtl/euler_path_finder_top.sv =====
// euler_path_finder_top: euler cycle / path search over a small undirected graph
//
// input channel (i_valid / o_ready): i_action selects add edge, run or clear.
// add and clear complete while idle and produce no output. loops, repeated
// edges and vertices at or above NUM_VERTICES are dropped.
// a run scans the degree parity of one vertex per cycle, then walks the graph
// with a stack: S_WALK pushes once per edge taken, and a pop passes through
// S_WALK and S_POP, since the stack memory has a registered read port. results
// leave one at a time through S_RD and S_OUT, each read from the path memory first.
// o_ready stays low for the whole run, also while the receiver stalls.
// output channel (o_valid / i_ready): o_vertex in pop order, o_last on the
// final request, o_found low on the single failure request (vertex 0).
// a stalled result simply holds until taken; nothing else advances meanwhile.
// every run leaves the graph empty.
// reset (synchronous, active low) empties the graph and returns to idle.
module euler_path_finder_top #(
    parameter int NUM_VERTICES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_action,
    input  eul_pkg::t_vtx i_vertex_a,
    input  eul_pkg::t_vtx i_vertex_b,
    output logic          o_valid,
    input  logic          i_ready,
    output eul_pkg::t_vtx o_vertex,
    output logic          o_last,
    output logic          o_found
);
    import eul_pkg::*;

    localparam int NV = eff_vertices(NUM_VERTICES);

    t_state    r_state, n_state;
    t_vtx      r_vidx;
    logic [1:0] r_odd;
    logic      r_have_odd;
    t_vtx      r_start;
    t_vtx      r_top;
    t_addr     r_depth;
    t_addr     r_plen;
    t_addr     r_k;

    t_adj_cmd  s_cmd;
    t_adj_stat s_stat;
    logic      s_accept;
    logic      s_push;
    logic      s_scan_end;
    logic [1:0] s_odd_next;
    logic      s_too_odd;
    t_vtx      s_start;

    logic      s_stk_we, s_stk_re;
    t_addr     s_stk_waddr, s_stk_raddr;
    t_vtx      s_stk_rdata;
    logic      s_pth_we, s_pth_re;
    t_vtx      s_pth_rdata;

    eul_adj #(
        .NUM_VERTICES(NUM_VERTICES)
    ) u_adj (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (s_cmd),
        .o_stat (s_stat)
    );

    eul_ram u_stack (
        .i_clk  (i_clk),
        .i_we   (s_stk_we),
        .i_waddr(s_stk_waddr),
        .i_wdata(r_top),
        .i_re   (s_stk_re),
        .i_raddr(s_stk_raddr),
        .o_rdata(s_stk_rdata)
    );

    eul_ram u_path (
        .i_clk  (i_clk),
        .i_we   (s_pth_we),
        .i_waddr(r_plen),
        .i_wdata(r_top),
        .i_re   (s_pth_re),
        .i_raddr(r_k),
        .o_rdata(s_pth_rdata)
    );

    assign s_accept   = i_valid && o_ready;
    assign s_push     = s_stat.row_nz && (r_depth < ADDR_W'(STORE_DEPTH));
    assign s_scan_end = (r_vidx == VTX_W'(NV - 1));
    assign s_odd_next = (s_stat.odd && r_odd != 2'd3) ? 2'(r_odd + 1'b1) : r_odd;
    assign s_too_odd  = (s_odd_next == 2'd3);
    assign s_start    = r_have_odd ? r_start : (s_stat.odd ? r_vidx : '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept && i_action == ACT_RUN) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (s_scan_end) begin
                    n_state = s_too_odd ? S_FAIL : S_WALK;
                end
            end
            S_WALK: begin
                if (!s_push) begin
                    n_state = (r_depth == ADDR_W'(1)) ? S_DONE : S_POP;
                end
            end
            S_POP:  n_state = S_WALK;
            S_DONE: n_state = (s_stat.edges_left || r_plen == '0) ? S_FAIL : S_RD;
            S_FAIL: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_RD:   n_state = S_OUT;
            S_OUT: begin
                if (i_ready) begin
                    n_state = o_last ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and unit controls
    always_comb begin
        s_cmd       = '0;
        s_stk_we    = 1'b0;
        s_stk_re    = 1'b0;
        s_stk_waddr = ADDR_W'(r_depth - 1'b1);
        s_stk_raddr = ADDR_W'(r_depth - 2'd2);
        s_pth_we    = 1'b0;
        s_pth_re    = 1'b0;
        o_ready     = 1'b0;
        o_valid     = 1'b0;
        o_vertex    = '0;
        o_last      = 1'b0;
        o_found     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                s_cmd.rd_vtx = i_vertex_a;
                s_cmd.va     = i_vertex_a;
                s_cmd.vb     = i_vertex_b;
                s_cmd.add    = i_valid && i_action == ACT_ADD;
                s_cmd.clear  = i_valid && i_action == ACT_CLEAR;
            end
            S_SCAN: begin
                s_cmd.rd_vtx = r_vidx;
                s_cmd.clear  = s_scan_end && s_too_odd;
            end
            S_WALK: begin
                s_cmd.rd_vtx = r_top;
                s_cmd.va     = r_top;
                s_cmd.vb     = s_stat.low_nbr;
                s_cmd.remove = s_push;
                s_stk_we     = s_push;
                s_stk_re     = !s_push && r_depth != ADDR_W'(1);
                s_pth_we     = !s_push && r_plen < ADDR_W'(STORE_DEPTH);
            end
            S_DONE: begin
                s_cmd.clear = 1'b1;
            end
            S_FAIL: begin
                o_valid = 1'b1;
                o_last  = 1'b1;
            end
            S_RD: begin
                s_pth_re = 1'b1;
            end
            S_OUT: begin
                o_valid  = 1'b1;
                o_vertex = s_pth_rdata;
                o_last   = (ADDR_W'(r_k + 1'b1) == r_plen);
                o_found  = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vidx     <= '0;
            r_odd      <= '0;
            r_have_odd <= 1'b0;
            r_start    <= '0;
            r_top      <= '0;
            r_depth    <= '0;
            r_plen     <= '0;
            r_k        <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_vidx     <= '0;
                    r_odd      <= '0;
                    r_have_odd <= 1'b0;
                end
                S_SCAN: begin
                    r_vidx <= VTX_W'(r_vidx + 1'b1);
                    r_odd  <= s_odd_next;
                    if (s_stat.odd && !r_have_odd) begin
                        r_have_odd <= 1'b1;
                        r_start    <= r_vidx;
                    end
                    if (s_scan_end) begin
                        r_top   <= s_start;
                        r_depth <= ADDR_W'(1);
                        r_plen  <= '0;
                    end
                end
                S_WALK: begin
                    if (s_push) begin
                        r_top   <= s_stat.low_nbr;
                        r_depth <= ADDR_W'(r_depth + 1'b1);
                    end else begin
                        r_depth <= ADDR_W'(r_depth - 1'b1);
                        if (s_pth_we) begin
                            r_plen <= ADDR_W'(r_plen + 1'b1);
                        end
                    end
                end
                S_POP: begin
                    r_top <= s_stk_rdata;
                end
                S_DONE: begin
                    r_k <= '0;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_k <= ADDR_W'(r_k + 1'b1);
                    end
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    // no new request while a result is pending
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("request accepted while result pending");

    // stack never grows past its store
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= ADDR_W'(STORE_DEPTH))
        else $error("walk stack overflow");

    // graph is empty once the final result of a run is taken
    a_graph_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> !s_stat.edges_left)
        else $error("graph not empty after run");

    // a push makes the chosen neighbour the new top
    a_push_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && s_push) |=> (r_top == $past(s_stat.low_nbr)))
        else $error("stack top not updated on push");

endmodule
